// ----- sv/lens_byte_exchange_master_assert.svh -----
// Assertion macros shared by the lens byte exchange RTL.
`ifndef LENS_BYTE_EXCHANGE_MASTER_ASSERT_SVH
`define LENS_BYTE_EXCHANGE_MASTER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define LBX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbx: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define LBX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbx: next-cycle check failed");

`endif

// ----- sv/lbx_pkg.sv -----
`timescale 1ns / 1ps

package lbx_pkg;

    // Bits moved in one exchange, most significant bit first.
    localparam int BITS_PER_EXCHANGE = 8;
    localparam int BYTE_W = 8;
    localparam int CNT_W = 4;
    localparam int WAIT_W = 16;
    localparam int TICK_W = 10;

    // Register reset values.
    localparam logic [TICK_W-1:0] HALF_BIT_RST = 10'd10;
    localparam logic [TICK_W-1:0] RELEASE_RST = 10'd10;
    localparam logic [WAIT_W-1:0] TIMEOUT_RST = 16'd3000;
    localparam logic [TICK_W-1:0] POST_BUSY_RST = 10'd40;

    localparam logic [BYTE_W-1:0] RX_TIMEOUT = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HALF_BIT  = 2'd0,
        CFG_RELEASE   = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_POST_BUSY = 2'd3
    } t_cfg_reg;

    // Exchange sequencer phases.
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LOW     = 6'b000010,
        PH_HIGH    = 6'b000100,
        PH_RELEASE = 6'b001000,
        PH_BUSY    = 6'b010000,
        PH_POST    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] half_bit_ticks;
        logic [TICK_W-1:0] release_ticks;
        logic [WAIT_W-1:0] busy_timeout_ticks;
        logic [TICK_W-1:0] post_busy_ticks;
    } t_cfg;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] tx_byte;
        logic              data_in_level;
        logic              clock_line_level;
    } t_item;

    typedef struct packed {
        logic              clock_drive_enable;
        logic              clock_out_level;
        logic              data_out_level;
        logic              exchange_busy;
        logic              exchange_done;
        logic [BYTE_W-1:0] rx_byte;
        logic              timed_out;
    } t_result;

endpackage

// ----- sv/lens_byte_exchange_master.sv -----
`timescale 1ns / 1ps

// Tick-driven master for one byte exchange on a lens link with a shared,
// open-drain clock line that idles high. Each input item is either one time
// tick or a start request carrying the byte to send; every item yields one
// result item with the line drive levels, the busy flag and, on the tick the
// exchange ends, the done pulse with the received byte (0xFF with timed_out
// set when the partner held the clock low past the timeout). One item is
// accepted per clock cycle; an item passes through an input register and then
// the sequencer into the result buffer, from which its result is offered. A
// two-entry output buffer keeps input accepted while a result waits to be
// taken; the input stalls only while both entries hold results. Timing
// registers are to be written through the configuration port only while the
// block is idle; the block itself does not enforce this.
module lens_byte_exchange_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick and start items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] tx_byte, [8] data_in_level, [9] clock_line_level, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] clock_drive_enable, [1] clock_out_level, [2] data_out_level,
    // [3] exchange_busy, [4] exchange_done, [12:5] rx_byte, [13] timed_out,
    // [15:14] zero
    output logic [15:0] m_axis_tdata,
    // Configuration write port.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lbx_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    t_cfg    r_cfg;
    logic    w_fire;
    logic    w_space;
    t_result w_result;
    t_result w_out;

    // Input register stage.
    assign w_fire        = r_in_valid && w_space;
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action           <= s_axis_tuser;
            r_in.tx_byte          <= s_axis_tdata[7:0];
            r_in.data_in_level    <= s_axis_tdata[8];
            r_in.clock_line_level <= s_axis_tdata[9];
        end
    end

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks     <= HALF_BIT_RST;
            r_cfg.release_ticks      <= RELEASE_RST;
            r_cfg.busy_timeout_ticks <= TIMEOUT_RST;
            r_cfg.post_busy_ticks    <= POST_BUSY_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_HALF_BIT:  r_cfg.half_bit_ticks     <= i_cfg_data[TICK_W-1:0];
                CFG_RELEASE:   r_cfg.release_ticks      <= i_cfg_data[TICK_W-1:0];
                CFG_TIMEOUT:   r_cfg.busy_timeout_ticks <= i_cfg_data;
                CFG_POST_BUSY: r_cfg.post_busy_ticks    <= i_cfg_data[TICK_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // Bit sequencer.
    lbx_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register and skid.
    lbx_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {2'b00, w_out.timed_out, w_out.rx_byte, w_out.exchange_done,
                           w_out.exchange_busy, w_out.data_out_level,
                           w_out.clock_out_level, w_out.clock_drive_enable};

endmodule

// ----- sv/lbx_core.sv -----
`timescale 1ns / 1ps

`include "lens_byte_exchange_master_assert.svh"

module lbx_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lbx_pkg::t_item   i_item,
    input  lbx_pkg::t_cfg    i_cfg,
    output lbx_pkg::t_result o_result
);
    import lbx_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [CNT_W-1:0]    r_bit,    n_bit;
    logic [BYTE_W-1:0]   r_send,   n_send;
    logic [BYTE_W-1:0]   r_recv,   n_recv;
    logic [WAIT_W-1:0]   r_wait,   n_wait;
    logic                r_clk_en, n_clk_en;
    logic                r_dout,   n_dout;

    logic [TICK_W-1:0]   w_half;
    logic [WAIT_W-1:0]   w_wait_inc;
    logic                w_done;
    logic                w_tout;
    logic [BYTE_W-1:0]   w_rx;

    // Next state of the bit sequencer for the current tick.
    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_send   = r_send;
        n_recv   = r_recv;
        n_wait   = r_wait;
        n_clk_en = r_clk_en;
        n_dout   = r_dout;
        w_done   = 1'b0;
        w_tout   = 1'b0;
        w_rx     = '0;
        w_half   = (i_cfg.half_bit_ticks == '0) ? TICK_W'(1) : i_cfg.half_bit_ticks;
        w_wait_inc = r_wait + WAIT_W'(1);
        case (r_phase)
            PH_IDLE: begin
                if (i_item.action) begin
                    n_clk_en = 1'b1;
                    n_recv   = '0;
                    n_bit    = '0;
                    n_dout   = i_item.tx_byte[BYTE_W-1];
                    n_send   = {i_item.tx_byte[BYTE_W-2:0], 1'b0};
                    n_phase  = PH_LOW;
                    n_wait   = '0;
                end
            end
            PH_LOW: begin
                n_wait = w_wait_inc;
                if (w_wait_inc >= WAIT_W'(w_half)) begin
                    n_recv  = {r_recv[BYTE_W-2:0], i_item.data_in_level};
                    n_bit   = r_bit + CNT_W'(1);
                    n_phase = PH_HIGH;
                    n_wait  = '0;
                end
            end
            PH_HIGH: begin
                n_wait = w_wait_inc;
                if (w_wait_inc >= WAIT_W'(w_half)) begin
                    n_wait = '0;
                    if (r_bit >= CNT_W'(BITS_PER_EXCHANGE)) begin
                        n_clk_en = 1'b0;
                        n_phase  = PH_RELEASE;
                    end else begin
                        n_dout  = r_send[BYTE_W-1];
                        n_send  = {r_send[BYTE_W-2:0], 1'b0};
                        n_phase = PH_LOW;
                    end
                end
            end
            PH_RELEASE: begin
                n_wait = w_wait_inc;
                if (w_wait_inc >= WAIT_W'(i_cfg.release_ticks)) begin
                    n_phase = PH_BUSY;
                    n_wait  = '0;
                end
            end
            PH_BUSY: begin
                // The partner holds the clock low while it is busy.
                if (i_item.clock_line_level) begin
                    n_phase = PH_POST;
                    n_wait  = '0;
                end else if (r_wait >= i_cfg.busy_timeout_ticks) begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                    w_done  = 1'b1;
                    w_tout  = 1'b1;
                    w_rx    = RX_TIMEOUT;
                end else begin
                    n_wait = w_wait_inc;
                end
            end
            PH_POST: begin
                n_wait = w_wait_inc;
                if (w_wait_inc >= WAIT_W'(i_cfg.post_busy_ticks)) begin
                    n_clk_en = 1'b1;
                    n_phase  = PH_IDLE;
                    n_wait   = '0;
                    w_done   = 1'b1;
                    w_rx     = r_recv;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_wait  = '0;
            end
        endcase
    end

    // Result of the tick, seen after its state update.
    always_comb begin
        o_result.clock_drive_enable = n_clk_en;
        o_result.clock_out_level    = (n_phase != PH_LOW);
        o_result.data_out_level     = n_dout;
        o_result.exchange_busy      = (n_phase != PH_IDLE);
        o_result.exchange_done      = w_done;
        o_result.rx_byte            = w_rx;
        o_result.timed_out          = w_tout;
    end

    // Sequencer state advances once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= '0;
            r_send   <= '0;
            r_recv   <= '0;
            r_wait   <= '0;
            r_clk_en <= 1'b1;
            r_dout   <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_send   <= n_send;
            r_recv   <= n_recv;
            r_wait   <= n_wait;
            r_clk_en <= n_clk_en;
            r_dout   <= n_dout;
        end
    end

    // The bit counter never runs past one exchange.
    `LBX_ASSERT_NOW(a_bit_range, i_clk, i_rst_n, 1'b1, r_bit <= CNT_W'(BITS_PER_EXCHANGE))
    // The clock stays released from the end of the last bit until completion.
    `LBX_ASSERT_NOW(a_released, i_clk, i_rst_n,
        (r_phase == PH_RELEASE) || (r_phase == PH_BUSY) || (r_phase == PH_POST), !r_clk_en)
    // A completed exchange always returns the sequencer to idle.
    `LBX_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, i_fire && w_done, r_phase == PH_IDLE)

endmodule

// ----- sv/lbx_out_buf.sv -----
`timescale 1ns / 1ps

`include "lens_byte_exchange_master_assert.svh"

module lbx_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lbx_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output lbx_pkg::t_result o_data
);
    import lbx_pkg::*;

    t_result    r_buf0;
    t_result    r_buf1;
    logic [1:0] r_count;
    logic       w_pop;

    // Two-entry skid: a result waits here while the next item is worked on.
    assign w_pop   = (r_count != 2'd0) && i_ready;
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf0;

    // Entry payload moves toward the head as results leave.
    always_ff @(posedge i_clk) begin
        if (i_push && !w_pop) begin
            if (r_count == 2'd0) begin
                r_buf0 <= i_data;
            end else begin
                r_buf1 <= i_data;
            end
        end else if (w_pop && !i_push) begin
            r_buf0 <= r_buf1;
        end else if (w_pop && i_push) begin
            if (r_count == 2'd1) begin
                r_buf0 <= i_data;
            end else begin
                r_buf0 <= r_buf1;
                r_buf1 <= i_data;
            end
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_push && !w_pop) begin
            r_count <= r_count + 2'd1;
        end else if (w_pop && !i_push) begin
            r_count <= r_count - 2'd1;
        end
    end

    // The buffer never holds more than two results.
    `LBX_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    // A push never lands in a full buffer.
    `LBX_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, i_push, r_count != 2'd2)

endmodule
